### rtl/core/hsi2rgbw_pkg.sv
// ----------------------------------------------------------------------------
// HSI to RGBW duty package
// Shared payload types, sector codes, fixed-point constants and the ratio ROM
// that is built at elaboration from a fixed-point cosine series.
// ----------------------------------------------------------------------------
package hsi2rgbw_pkg;

    // Default widths of the fractional channel value and of the PWM duty.
    localparam int FRAC_BITS_DEF     = 8;
    localparam int MAX_DUTY_BITS_DEF = 16;

    // Configuration port.
    localparam int              PADDR_W       = 3;
    localparam logic [0:0]      REG_DUTY_BITS = 1'b0;
    localparam logic [4:0]      DUTY_BITS_RST = 5'd8;

    // Hue handling.
    localparam logic [8:0] HUE_TURN      = 9'd360;
    localparam logic [8:0] SECTOR_DEG    = 9'd120;
    localparam logic [8:0] SECTOR2_START = 9'd240;
    localparam int         ROM_DEPTH     = 120;
    localparam int         OFF_W         = $clog2(ROM_DEPTH);

    // Ratio ROM words are signed Q2.14 values in (-1, 2].
    localparam int RATIO_W  = 17;
    localparam int ROM_FRAC = 14;
    localparam int FACTOR_W = 16;
    localparam int PROD_W   = 16;
    localparam int LIT_W    = PROD_W + FACTOR_W;

    // Divisors of the lit and white channel fractions.
    localparam logic [63:0] LIT_DIV   = 64'd3 * 64'd65025 * (64'd1 << ROM_FRAC);
    localparam logic [63:0] WHITE_DIV = 64'd65025;

    // Pipeline depths of the individual units.
    localparam int FRONT_LAT = 3;
    localparam int CDIV_LAT  = 3;
    localparam int SCALE_LAT = 2;

    typedef enum logic [1:0] {
        SECT_RG = 2'd0,
        SECT_GB = 2'd1,
        SECT_BR = 2'd2
    } sector_t;

    typedef struct packed {
        logic [8:0] hue_deg;
        logic [7:0] sat_frac;
        logic [7:0] level_frac;
    } hsi_in_t;

    typedef struct packed {
        logic [15:0] red_duty;
        logic [15:0] green_duty;
        logic [15:0] blue_duty;
        logic [15:0] white_duty;
    } duty_out_t;

    typedef logic [ROM_DEPTH-1:0][RATIO_W-1:0] ratio_table_t;

    localparam logic [63:0] PI_Q40   = 64'h3243F6A8886;
    localparam logic [63:0] ANG_RND  = 64'd180 << 11;
    localparam logic [63:0] ANG_DEN  = 64'd180 << 12;
    localparam int          ANG_FRAC = 28;
    localparam int          SERIES_TERMS = 12;

    // Restoring long division, used only while the ROM is built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Cosine of a whole number of degrees in Q28, by a truncated Taylor series.
    function automatic logic signed [63:0] cos_q28(input logic [63:0] deg);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = udiv64(deg * PI_Q40 + ANG_RND, ANG_DEN);
        x2   = (x * x) >> ANG_FRAC;
        term = 64'd1 << ANG_FRAC;
        sum  = $signed(term);
        for (int k = 1; k <= SERIES_TERMS; k++)
        begin
            term = udiv64((term * x2) >> ANG_FRAC, 64'((2 * k - 1) * (2 * k)));
            if (k % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        return sum;
    endfunction

    function automatic ratio_table_t build_rom();
        ratio_table_t       tbl;
        logic signed [63:0] c;
        logic signed [63:0] d;
        logic [63:0]        mag;
        logic [63:0]        q;
        logic [63:0]        entry;
        tbl = '0;
        for (int h = 0; h < ROM_DEPTH; h++)
        begin
            c = cos_q28(64'(h));
            d = cos_q28((h < 60) ? 64'(60 - h) : 64'(h - 60));
            mag = (c < 0) ? 64'(-c) : 64'(c);
            if (d <= 0)
                d = 64'sd1;
            q = udiv64((mag << ROM_FRAC) + (64'(d) >> 1), 64'(d));
            entry = (c < 0) ? (64'd0 - q) : q;
            tbl[h] = entry[RATIO_W-1:0];
        end
        return tbl;
    endfunction

    localparam ratio_table_t RATIO_ROM = build_rom();

endpackage

### rtl/core/hsi2rgbw_front.sv
// ----------------------------------------------------------------------------
// HSI to RGBW front end
// Wraps the hue, finds the sector, looks up the ratio and forms the products
// of saturation, intensity and the two lit-channel factors.
// ----------------------------------------------------------------------------
module hsi2rgbw_front
    import hsi2rgbw_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  hsi_in_t           pix,
    output sector_t           sector,
    output logic [LIT_W-1:0]  lit_a,
    output logic [LIT_W-1:0]  lit_b,
    output logic [PROD_W-1:0] white_prod
);

    // Stage 1: sector and offset, saturation and intensity products.
    logic [8:0]        hue_w;
    sector_t           sector_s1_next;
    logic [OFF_W-1:0]  off_s1_next;
    logic [PROD_W-1:0] prod_s1_next;
    logic [PROD_W-1:0] white_s1_next;

    sector_t           sector_s1_reg;
    logic [OFF_W-1:0]  off_s1_reg;
    logic [PROD_W-1:0] prod_s1_reg;
    logic [PROD_W-1:0] white_s1_reg;

    always_comb
    begin
        hue_w = (pix.hue_deg >= HUE_TURN) ? (pix.hue_deg - HUE_TURN) : pix.hue_deg;
        priority if (hue_w < SECTOR_DEG)
        begin
            sector_s1_next = SECT_RG;
            off_s1_next    = hue_w[OFF_W-1:0];
        end
        else if (hue_w < SECTOR2_START)
        begin
            sector_s1_next = SECT_GB;
            off_s1_next    = OFF_W'(hue_w - SECTOR_DEG);
        end
        else
        begin
            sector_s1_next = SECT_BR;
            off_s1_next    = OFF_W'(hue_w - SECTOR2_START);
        end
        prod_s1_next  = PROD_W'(pix.sat_frac) * PROD_W'(pix.level_frac);
        // The complement of an 8-bit fraction is 255 minus it.
        white_s1_next = PROD_W'(8'd255 - pix.sat_frac) * PROD_W'(pix.level_frac);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sector_s1_reg <= sector_s1_next;
            off_s1_reg    <= off_s1_next;
            prod_s1_reg   <= prod_s1_next;
            white_s1_reg  <= white_s1_next;
        end
    end

    // Stage 2: ratio lookup and the two lit factors, clamped at zero.
    logic signed [RATIO_W-1:0] ratio;
    logic signed [RATIO_W:0]   fac_a;
    logic signed [RATIO_W:0]   fac_b;
    logic [FACTOR_W-1:0]       fac_a_s2_next;
    logic [FACTOR_W-1:0]       fac_b_s2_next;

    sector_t             sector_s2_reg;
    logic [FACTOR_W-1:0] fac_a_s2_reg;
    logic [FACTOR_W-1:0] fac_b_s2_reg;
    logic [PROD_W-1:0]   prod_s2_reg;
    logic [PROD_W-1:0]   white_s2_reg;

    always_comb
    begin
        ratio = $signed(RATIO_ROM[off_s1_reg]);
        fac_a = $signed((RATIO_W+1)'(1 << ROM_FRAC)) + (RATIO_W+1)'(ratio);
        fac_b = $signed((RATIO_W+1)'(2 << ROM_FRAC)) - (RATIO_W+1)'(ratio);
        fac_a_s2_next = (fac_a < 0) ? '0 : fac_a[FACTOR_W-1:0];
        fac_b_s2_next = (fac_b < 0) ? '0 : fac_b[FACTOR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sector_s2_reg <= sector_s1_reg;
            fac_a_s2_reg  <= fac_a_s2_next;
            fac_b_s2_reg  <= fac_b_s2_next;
            prod_s2_reg   <= prod_s1_reg;
            white_s2_reg  <= white_s1_reg;
        end
    end

    // Stage 3: lit-channel numerators.
    logic [LIT_W-1:0] lit_a_next;
    logic [LIT_W-1:0] lit_b_next;

    sector_t           sector_s3_reg;
    logic [LIT_W-1:0]  lit_a_reg;
    logic [LIT_W-1:0]  lit_b_reg;
    logic [PROD_W-1:0] white_s3_reg;

    always_comb
    begin
        lit_a_next = LIT_W'(prod_s2_reg) * LIT_W'(fac_a_s2_reg);
        lit_b_next = LIT_W'(prod_s2_reg) * LIT_W'(fac_b_s2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sector_s3_reg <= sector_s2_reg;
            lit_a_reg     <= lit_a_next;
            lit_b_reg     <= lit_b_next;
            white_s3_reg  <= white_s2_reg;
        end
    end

    assign sector     = sector_s3_reg;
    assign lit_a      = lit_a_reg;
    assign lit_b      = lit_b_reg;
    assign white_prod = white_s3_reg;

endmodule

### rtl/core/hsi2rgbw_cdiv.sv
// ----------------------------------------------------------------------------
// HSI to RGBW constant divider
// Computes floor(num * 2^FB / DIV) in three stages: a reciprocal estimate,
// a back-multiplication and a single correction step.
// ----------------------------------------------------------------------------
module hsi2rgbw_cdiv
    import hsi2rgbw_pkg::*;
#(
    parameter int          PW  = LIT_W,
    parameter int          FB  = FRAC_BITS_DEF,
    parameter logic [63:0] DIV = LIT_DIV
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [PW-1:0] num,
    output logic [FB:0]   quo
);

    localparam int          MW        = FB + 1;
    localparam int          CW        = PW + FB + 1;
    localparam logic [63:0] MULT_FULL = (64'd1 << (PW + FB)) / DIV;
    localparam logic [MW-1:0] MULT    = MULT_FULL[MW-1:0];
    localparam logic [CW-1:0] DIV_C   = DIV[CW-1:0];

    // The estimate is low by at most one, because the reciprocal error times
    // a numerator below 2^PW stays under one.
    logic [PW+MW-1:0] est_prod;
    logic [FB:0]      est_s1_reg;
    logic [PW-1:0]    num_s1_reg;

    assign est_prod = {{MW{1'b0}}, num} * {{PW{1'b0}}, MULT};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            est_s1_reg <= est_prod[PW+MW-1:PW];
            num_s1_reg <= num;
        end
    end

    logic [CW-1:0] back_next;
    logic [CW-1:0] back_s2_reg;
    logic [FB:0]   est_s2_reg;
    logic [PW-1:0] num_s2_reg;

    assign back_next = {{(CW-MW){1'b0}}, est_s1_reg} * DIV_C;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            back_s2_reg <= back_next;
            est_s2_reg  <= est_s1_reg;
            num_s2_reg  <= num_s1_reg;
        end
    end

    logic [CW-1:0] rem;
    logic [FB:0]   quo_next;
    logic [FB:0]   quo_reg;

    always_comb
    begin
        rem      = {1'b0, num_s2_reg, {FB{1'b0}}} - back_s2_reg;
        quo_next = est_s2_reg + ((rem >= DIV_C) ? MW'(1) : MW'(0));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

### rtl/core/hsi2rgbw_scale.sv
// ----------------------------------------------------------------------------
// HSI to RGBW duty scaler
// Scales a channel fraction to the PWM full scale and truncates it, capped at
// full scale.
// ----------------------------------------------------------------------------
module hsi2rgbw_scale
    import hsi2rgbw_pkg::*;
#(
    parameter int FB  = FRAC_BITS_DEF,
    parameter int MDB = MAX_DUTY_BITS_DEF
)
(
    input  logic           clk,
    input  logic           en,
    input  logic [MDB-1:0] full,
    input  logic [FB:0]    frac,
    output logic [MDB-1:0] duty
);

    localparam int PW = MDB + FB + 1;

    logic [PW-1:0] prod_next;
    logic [PW-1:0] prod_reg;

    assign prod_next = PW'(full) * PW'(frac);

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    logic [MDB:0]   shifted;
    logic [MDB-1:0] duty_next;
    logic [MDB-1:0] duty_reg;

    always_comb
    begin
        shifted   = prod_reg[PW-1:FB];
        duty_next = (shifted > {1'b0, full}) ? full : shifted[MDB-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            duty_reg <= duty_next;
    end

    assign duty = duty_reg;

endmodule

### rtl/core/hsi_to_rgbw_duty_unit.sv
// ----------------------------------------------------------------------------
// HSI to RGBW PWM duty converter
// Converts a hue, saturation and intensity colour into red, green, blue and
// white PWM duties at a programmable resolution.
//
// Colours enter on the pix channel and duties leave on the duty channel, both
// with a valid/ready handshake; one transfer carries one colour or one set of
// four duties. The converter is a nine-stage pipeline: three front stages
// (sector and ROM lookup, products), three stages of constant division, two
// of scaling and the output register. A new colour can be taken in every
// cycle while no result is held at the output.
// When the receiver holds duty_ready low with a result waiting, the whole
// pipeline freezes and pix_ready falls; nothing is dropped or repeated.
// Reset empties the pipeline and sets the resolution register to eight bits.
// The resolution register sits at address 0 of the APB port and should only
// be written while no colour is in flight.
// ----------------------------------------------------------------------------
module hsi_to_rgbw_duty_unit
    import hsi2rgbw_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int MAX_DUTY_BITS = MAX_DUTY_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_ready,
    input  hsi_in_t            pix_data,
    output logic               duty_valid,
    input  logic               duty_ready,
    output duty_out_t          duty_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int NSTAGE   = FRONT_LAT + CDIV_LAT + SCALE_LAT + 1;
    localparam int SECT_DLY = CDIV_LAT + SCALE_LAT;

    // Configuration register.
    logic [4:0] duty_bits_reg;
    logic       cfg_hit;

    assign cfg_hit = (paddr[PADDR_W-1:2] == REG_DUTY_BITS);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? {27'd0, duty_bits_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            duty_bits_reg <= DUTY_BITS_RST;
        else if (psel && penable && pwrite && pready && cfg_hit)
            duty_bits_reg <= pwdata[4:0];
    end

    logic [4:0]               bits_eff;
    logic [MAX_DUTY_BITS:0]   full_one;
    logic [MAX_DUTY_BITS-1:0] full;

    always_comb
    begin
        bits_eff = (duty_bits_reg > 5'(MAX_DUTY_BITS)) ? 5'(MAX_DUTY_BITS) : duty_bits_reg;
        full_one = (MAX_DUTY_BITS+1)'(1) << bits_eff;
        full     = full_one[MAX_DUTY_BITS-1:0] - MAX_DUTY_BITS'(1);
    end

    // Pipeline control: every stage moves together unless a result is held.
    logic              en;
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;

    assign en         = ~valid_reg[NSTAGE-1] | duty_ready;
    assign pix_ready  = en;
    assign valid_next = {valid_reg[NSTAGE-2:0], pix_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    // Datapath.
    sector_t           sector;
    logic [LIT_W-1:0]  lit_a;
    logic [LIT_W-1:0]  lit_b;
    logic [PROD_W-1:0] white_prod;

    hsi2rgbw_front u_front (
        .clk        (clk),
        .en         (en),
        .pix        (pix_data),
        .sector     (sector),
        .lit_a      (lit_a),
        .lit_b      (lit_b),
        .white_prod (white_prod)
    );

    logic [FRAC_BITS:0] frac_a;
    logic [FRAC_BITS:0] frac_b;
    logic [FRAC_BITS:0] frac_w;

    hsi2rgbw_cdiv #(.PW(LIT_W), .FB(FRAC_BITS), .DIV(LIT_DIV)) u_cdiv_a (
        .clk (clk),
        .en  (en),
        .num (lit_a),
        .quo (frac_a)
    );

    hsi2rgbw_cdiv #(.PW(LIT_W), .FB(FRAC_BITS), .DIV(LIT_DIV)) u_cdiv_b (
        .clk (clk),
        .en  (en),
        .num (lit_b),
        .quo (frac_b)
    );

    hsi2rgbw_cdiv #(.PW(PROD_W), .FB(FRAC_BITS), .DIV(WHITE_DIV)) u_cdiv_w (
        .clk (clk),
        .en  (en),
        .num (white_prod),
        .quo (frac_w)
    );

    logic [MAX_DUTY_BITS-1:0] duty_a;
    logic [MAX_DUTY_BITS-1:0] duty_b;
    logic [MAX_DUTY_BITS-1:0] duty_w;

    hsi2rgbw_scale #(.FB(FRAC_BITS), .MDB(MAX_DUTY_BITS)) u_scale_a (
        .clk  (clk),
        .en   (en),
        .full (full),
        .frac (frac_a),
        .duty (duty_a)
    );

    hsi2rgbw_scale #(.FB(FRAC_BITS), .MDB(MAX_DUTY_BITS)) u_scale_b (
        .clk  (clk),
        .en   (en),
        .full (full),
        .frac (frac_b),
        .duty (duty_b)
    );

    hsi2rgbw_scale #(.FB(FRAC_BITS), .MDB(MAX_DUTY_BITS)) u_scale_w (
        .clk  (clk),
        .en   (en),
        .full (full),
        .frac (frac_w),
        .duty (duty_w)
    );

    // The sector travels beside the divider and scaler stages.
    sector_t sector_dly_reg [SECT_DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sector_dly_reg[0] <= sector;
            for (int i = 1; i < SECT_DLY; i++)
                sector_dly_reg[i] <= sector_dly_reg[i-1];
        end
    end

    // Output register: route the two lit duties to their colours.
    duty_out_t duty_data_next;
    duty_out_t duty_data_reg;

    always_comb
    begin
        duty_data_next.white_duty = 16'(duty_w);
        unique case (sector_dly_reg[SECT_DLY-1])
            SECT_RG:
            begin
                duty_data_next.red_duty   = 16'(duty_a);
                duty_data_next.green_duty = 16'(duty_b);
                duty_data_next.blue_duty  = 16'd0;
            end
            SECT_GB:
            begin
                duty_data_next.red_duty   = 16'd0;
                duty_data_next.green_duty = 16'(duty_a);
                duty_data_next.blue_duty  = 16'(duty_b);
            end
            SECT_BR:
            begin
                duty_data_next.red_duty   = 16'(duty_b);
                duty_data_next.green_duty = 16'd0;
                duty_data_next.blue_duty  = 16'(duty_a);
            end
            default:
            begin
                duty_data_next.red_duty   = 16'd0;
                duty_data_next.green_duty = 16'd0;
                duty_data_next.blue_duty  = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            duty_data_reg <= duty_data_next;
    end

    assign duty_valid = valid_reg[NSTAGE-1];
    assign duty_data  = duty_data_reg;

endmodule
